// ===== rtl/hfl_pkg.sv =====
// ----------------------------------------------------------------------------
// hfl_pkg
// Shared types, constants and helpers for the log-domain HMM forward block.
// ----------------------------------------------------------------------------
package hfl_pkg;

    localparam int NST       = 2;
    localparam int KW        = (NST > 1) ? $clog2(NST) : 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR3 = 3'd4;

    typedef logic signed [31:0] log_t;
    typedef log_t [NST-1:0] log_vec_t;

    localparam log_t LOG_MIN = 32'sh8000_0000;
    localparam log_t LOG_MAX = 32'sh7fff_ffff;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [47:0] EXP_LIMIT = 48'd1572864;
    localparam logic [16:0] PRIOR_ONE = 17'd65536;

    localparam logic [5:0] LN_F16 = 6'd16;
    localparam logic [5:0] LN_F32 = 6'd32;
    localparam logic [5:0] LN_F48 = 6'd48;

    typedef struct packed {
        logic [31:0] site_distance;
        log_t        emission_0;
        log_t        emission_1;
        log_t        emission_2;
        log_t        emission_3;
        logic        final_site;
    } site_t;

    typedef struct packed {
        log_t log_likelihood;
        logic sequence_end;
        logic saturated;
    } result_t;

    // log value with its saturation flag
    typedef struct packed {
        logic flag;
        log_t value;
    } log_res_t;

    // 2^(-2^-(idx+1)) in Q0.32
    function automatic logic [31:0] exp2_tab(input logic [3:0] idx);
        logic [31:0] t;
        case (idx)
            4'd0:    t = 32'd3037000500;
            4'd1:    t = 32'd3611622603;
            4'd2:    t = 32'd3938502376;
            4'd3:    t = 32'd4112874773;
            4'd4:    t = 32'd4202935003;
            4'd5:    t = 32'd4248701964;
            4'd6:    t = 32'd4271771997;
            4'd7:    t = 32'd4283353945;
            4'd8:    t = 32'd4289156690;
            4'd9:    t = 32'd4292061010;
            4'd10:   t = 32'd4293513907;
            4'd11:   t = 32'd4294240540;
            4'd12:   t = 32'd4294603903;
            4'd13:   t = 32'd4294785596;
            4'd14:   t = 32'd4294876445;
            default: t = 32'd4294921870;
        endcase
        return t;
    endfunction

    // minus infinity absorbs; finite overflow clamps and flags
    function automatic log_res_t sat_add(input log_t a, input log_t b);
        log_res_t          r;
        logic signed [32:0] s;
        s       = $signed({a[31], a}) + $signed({b[31], b});
        r.flag  = 1'b0;
        r.value = s[31:0];
        if (a == LOG_MIN || b == LOG_MIN) begin
            r.value = LOG_MIN;
        end
        else if (s > 33'sh0_7fff_ffff) begin
            r.flag  = 1'b1;
            r.value = LOG_MAX;
        end
        else if (s <= 33'sh1_8000_0000) begin
            r.flag  = 1'b1;
            r.value = LOG_MIN;
        end
        return r;
    endfunction

    function automatic log_t max_log(input log_vec_t v);
        log_t m;
        m = v[0];
        for (int i = 1; i < NST; i++) begin
            if ($signed(v[i]) > $signed(m)) begin
                m = v[i];
            end
        end
        return m;
    endfunction

    function automatic logic [16:0] prior_clamp(input logic [16:0] p);
        return (p > PRIOR_ONE) ? PRIOR_ONE : p;
    endfunction

endpackage

// ===== rtl/hfl_exp.sv =====
// ----------------------------------------------------------------------------
// hfl_exp
// Iterative exp(-x), x unsigned Q32.16, result Q1.32; one table step a cycle.
// ----------------------------------------------------------------------------
module hfl_exp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] x,
    output logic        done,
    output logic [32:0] result
);
    import hfl_pkg::*;

    typedef enum logic [1:0] {E_IDLE, E_SCALE, E_STEP, E_SHIFT} state_t;

    state_t      state_reg;
    logic        done_reg;
    logic [32:0] result_reg;
    logic [20:0] xs_reg;
    logic        zero_reg;
    logic [21:0] y_reg;
    logic [32:0] r_reg;
    logic [3:0]  b_reg;

    logic [51:0] scaled;
    logic [64:0] step_prod;
    logic [64:0] step_rnd;
    logic [5:0]  n;
    logic [33:0] shl;
    logic [33:0] rnd;

    assign scaled    = 52'(xs_reg) * 52'(LOG2E_Q30) + 52'h2000_0000;
    assign step_prod = 65'(r_reg) * 65'(exp2_tab(b_reg));
    assign step_rnd  = step_prod + 65'h8000_0000;
    assign n         = y_reg[21:16];
    // (r + 2^(n-1)) >> n, also right for n = 0
    assign shl       = {r_reg, 1'b0} >> n;
    assign rnd       = shl + 34'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        xs_reg    <= x[20:0];
                        zero_reg  <= (x >= EXP_LIMIT);
                        state_reg <= E_SCALE;
                    end
                end
                E_SCALE:
                begin
                    y_reg     <= scaled[51:30];
                    r_reg     <= 33'h1_0000_0000;
                    b_reg     <= 4'd0;
                    state_reg <= E_STEP;
                end
                E_STEP:
                begin
                    if (y_reg[4'(4'd15 - b_reg)])
                    begin
                        r_reg <= step_rnd[64:32];
                    end
                    if (b_reg == 4'd15)
                    begin
                        state_reg <= E_SHIFT;
                    end
                    else
                    begin
                        b_reg <= b_reg + 4'd1;
                    end
                end
                E_SHIFT:
                begin
                    result_reg <= (zero_reg || n >= 6'd33) ? 33'd0 : rnd[33:1];
                    done_reg   <= 1'b1;
                    state_reg  <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/hfl_ln.sv =====
// ----------------------------------------------------------------------------
// hfl_ln
// Iterative natural log of an unsigned Q(64-F).F value, result signed Q16.16.
// Binary-search normalisation, then one squaring per fraction bit.
// ----------------------------------------------------------------------------
module hfl_ln (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         v,
    input  logic [5:0]          fbits,
    output logic                done,
    output hfl_pkg::log_res_t   result
);
    import hfl_pkg::*;

    typedef enum logic [2:0] {N_IDLE, N_NORM, N_SQR, N_MUL, N_RND} state_t;

    state_t             state_reg;
    logic               done_reg;
    log_res_t           result_reg;
    logic [63:0]        w_reg;
    logic [5:0]         m_reg;
    logic [5:0]         f_reg;
    logic [2:0]         ncnt_reg;
    logic [4:0]         scnt_reg;
    logic [31:0]        x_reg;
    logic [23:0]        frac_reg;
    logic signed [63:0] p_reg;

    logic [5:0]         sh;
    logic               top_zero;
    logic [63:0]        w_next;
    logic [5:0]         m_next;
    logic [63:0]        sq;
    logic signed [6:0]  e_diff;
    logic signed [30:0] l_val;
    logic signed [63:0] p_mul;
    logic [63:0]        mag;
    logic [63:0]        mag_rnd;
    logic [23:0]        r_mag;
    logic [31:0]        r_val;

    assign sh       = 6'd32 >> ncnt_reg;
    assign top_zero = (w_reg >> 6'(7'd64 - 7'(sh))) == 64'd0;
    assign w_next   = top_zero ? (w_reg << sh) : w_reg;
    assign m_next   = top_zero ? (m_reg - sh) : m_reg;
    assign sq       = 64'(x_reg) * 64'(x_reg);
    assign e_diff   = $signed({1'b0, m_reg}) - $signed({1'b0, f_reg});
    assign l_val    = $signed({e_diff, frac_reg});
    assign p_mul    = 64'(l_val) * 64'($signed({1'b0, LN2_Q32}));
    assign mag      = p_reg[63] ? 64'(-p_reg) : 64'(p_reg);
    assign mag_rnd  = mag + 64'h80_0000_0000;
    assign r_mag    = mag_rnd[63:40];
    assign r_val    = p_reg[63] ? (32'd0 - 32'(r_mag)) : 32'(r_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        if (v == 64'd0)
                        begin
                            result_reg <= '{flag: 1'b1, value: LOG_MIN};
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            w_reg     <= v;
                            m_reg     <= 6'd63;
                            f_reg     <= fbits;
                            ncnt_reg  <= 3'd0;
                            state_reg <= N_NORM;
                        end
                    end
                end
                N_NORM:
                begin
                    w_reg    <= w_next;
                    m_reg    <= m_next;
                    ncnt_reg <= ncnt_reg + 3'd1;
                    if (ncnt_reg == 3'd5)
                    begin
                        x_reg     <= w_next[63:32];
                        scnt_reg  <= 5'd0;
                        frac_reg  <= 24'd0;
                        state_reg <= N_SQR;
                    end
                end
                N_SQR:
                begin
                    if (sq[63])
                    begin
                        x_reg    <= sq[63:32];
                        frac_reg <= {frac_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        x_reg    <= sq[62:31];
                        frac_reg <= {frac_reg[22:0], 1'b0};
                    end
                    scnt_reg <= scnt_reg + 5'd1;
                    if (scnt_reg == 5'd23)
                    begin
                        state_reg <= N_MUL;
                    end
                end
                N_MUL:
                begin
                    p_reg     <= p_mul;
                    state_reg <= N_RND;
                end
                N_RND:
                begin
                    // magnitude stays far below the clamp limits
                    result_reg <= '{flag: 1'b0, value: r_val};
                    done_reg   <= 1'b1;
                    state_reg  <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/hfl_lane.sv =====
// ----------------------------------------------------------------------------
// hfl_lane
// One hidden state: transition logs, log-sum-exp over predecessors, emission.
// ----------------------------------------------------------------------------
module hfl_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [hfl_pkg::KW-1:0] lane,
    input  logic [32:0]            c,
    input  logic [16:0]            prior,
    input  hfl_pkg::log_vec_t      score,
    input  hfl_pkg::log_t          emission,
    output logic                   done,
    output hfl_pkg::log_res_t      result
);
    import hfl_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE, L_LNO_GO, L_LNO_WAIT, L_LND_GO, L_LND_WAIT, L_TMP, L_MAX,
        L_EXP_GO, L_EXP_WAIT, L_LNS_GO, L_LNS_WAIT, L_LSE, L_EMIT
    } state_t;

    state_t          state_reg;
    logic            done_reg;
    log_res_t        result_reg;
    logic            flag_reg;
    log_t            lo_reg;
    log_t            ld_reg;
    log_vec_t        tmp_reg;
    log_t            mx_reg;
    log_t            lnv_reg;
    log_t            lse_reg;
    logic [34:0]     sum_reg;
    logic [KW-1:0]   k_reg;

    logic [32:0]     one_minus_c;
    logic [49:0]     off;
    logic [49:0]     dia;
    logic            ln_start;
    logic [63:0]     ln_v;
    logic [5:0]      ln_f;
    logic            ln_done;
    log_res_t        ln_res;
    logic            exp_start;
    logic [32:0]     exp_diff;
    logic            exp_done;
    logic [32:0]     exp_res;
    log_vec_t        tmp_val;
    logic            tmp_flag;
    log_t            mx_val;
    log_res_t        lse_sum;
    log_res_t        emit_sum;

    assign one_minus_c = 33'h1_0000_0000 - c;
    assign off         = 50'(one_minus_c) * 50'(prior);
    assign dia         = off + (50'(c) << 16);

    assign ln_start  = (state_reg == L_LNO_GO) || (state_reg == L_LND_GO) ||
                       (state_reg == L_LNS_GO);
    assign exp_start = (state_reg == L_EXP_GO);
    assign exp_diff  = 33'($signed({mx_reg[31], mx_reg}) -
                           $signed({tmp_reg[k_reg][31], tmp_reg[k_reg]}));

    always_comb
    begin
        ln_v = 64'(off);
        ln_f = LN_F48;
        if (state_reg == L_LNS_GO)
        begin
            ln_v = 64'(sum_reg);
            ln_f = LN_F32;
        end
        else if (state_reg == L_LND_GO)
        begin
            ln_v = 64'(dia);
        end
    end

    always_comb
    begin
        log_res_t t;
        tmp_flag = 1'b0;
        for (int k = 0; k < NST; k++)
        begin
            t          = sat_add(score[k], (KW'(k) == lane) ? ld_reg : lo_reg);
            tmp_val[k] = t.value;
            tmp_flag   = tmp_flag | t.flag;
        end
    end

    assign mx_val   = max_log(tmp_reg);
    assign lse_sum  = sat_add(mx_reg, lnv_reg);
    assign emit_sum = sat_add(lse_reg, emission);

    hfl_ln u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .v      (ln_v),
        .fbits  (ln_f),
        .done   (ln_done),
        .result (ln_res)
    );

    hfl_exp u_exp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .x      (48'(exp_diff)),
        .done   (exp_done),
        .result (exp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        flag_reg  <= 1'b0;
                        state_reg <= L_LNO_GO;
                    end
                end
                L_LNO_GO:
                begin
                    state_reg <= L_LNO_WAIT;
                end
                L_LNO_WAIT:
                begin
                    if (ln_done)
                    begin
                        lo_reg    <= ln_res.value;
                        flag_reg  <= flag_reg | ln_res.flag;
                        state_reg <= L_LND_GO;
                    end
                end
                L_LND_GO:
                begin
                    state_reg <= L_LND_WAIT;
                end
                L_LND_WAIT:
                begin
                    if (ln_done)
                    begin
                        ld_reg    <= ln_res.value;
                        flag_reg  <= flag_reg | ln_res.flag;
                        state_reg <= L_TMP;
                    end
                end
                L_TMP:
                begin
                    tmp_reg   <= tmp_val;
                    flag_reg  <= flag_reg | tmp_flag;
                    state_reg <= L_MAX;
                end
                L_MAX:
                begin
                    mx_reg  <= mx_val;
                    k_reg   <= '0;
                    sum_reg <= 35'd0;
                    if (mx_val == LOG_MIN)
                    begin
                        lse_reg   <= LOG_MIN;
                        state_reg <= L_EMIT;
                    end
                    else
                    begin
                        state_reg <= L_EXP_GO;
                    end
                end
                L_EXP_GO:
                begin
                    state_reg <= L_EXP_WAIT;
                end
                L_EXP_WAIT:
                begin
                    if (exp_done)
                    begin
                        sum_reg <= sum_reg + 35'(exp_res);
                        if (k_reg == KW'(NST - 1))
                        begin
                            state_reg <= L_LNS_GO;
                        end
                        else
                        begin
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= L_EXP_GO;
                        end
                    end
                end
                L_LNS_GO:
                begin
                    state_reg <= L_LNS_WAIT;
                end
                L_LNS_WAIT:
                begin
                    if (ln_done)
                    begin
                        lnv_reg   <= ln_res.value;
                        flag_reg  <= flag_reg | ln_res.flag;
                        state_reg <= L_LSE;
                    end
                end
                L_LSE:
                begin
                    lse_reg   <= lse_sum.value;
                    flag_reg  <= flag_reg | lse_sum.flag;
                    state_reg <= L_EMIT;
                end
                L_EMIT:
                begin
                    result_reg <= '{flag: flag_reg | emit_sum.flag, value: emit_sum.value};
                    done_reg   <= 1'b1;
                    state_reg  <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/hmm_forward_log_likelihood_top.sv =====
// ----------------------------------------------------------------------------
// hmm_forward_log_likelihood_top
// Log-domain HMM forward pass: per-state lanes, merge of running likelihood.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  site     | site_valid/site_stall   | site_t: distance, emissions, final
//  result   | result_valid/result_stall | result_t: log-likelihood, flags
//  cfg      | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
//  One site at a time; when a sequence starts, the prior of each state is
//  first loaded through ln. Processing time is set by the iterative ln unit
//  (24 squaring steps) and exp unit (16 table steps) in each lane and in
//  the merge stage. Reset clears control and config to defaults; no sweep.
//  A result waiting under result_stall does not block the next site transfer.
// ----------------------------------------------------------------------------
module hmm_forward_log_likelihood_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              site_valid,
    output logic                              site_stall,
    input  hfl_pkg::site_t                    site,
    output logic                              result_valid,
    input  logic                              result_stall,
    output hfl_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import hfl_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE, T_LOAD_GO, T_LOAD_WAIT, T_MULT, T_CEXP_GO, T_CEXP_WAIT,
        T_LANE_GO, T_LANE_WAIT, T_MMAX, T_MEXP_GO, T_MEXP_WAIT, T_MLN_GO,
        T_MLN_WAIT, T_MADD, T_OUT
    } state_t;

    state_t          state_reg;
    logic [31:0]     decay_reg;
    logic [16:0]     prior_reg [4];
    logic            open_reg;
    site_t           site_reg;
    logic            flag_reg;
    log_vec_t        score_reg;
    logic [KW-1:0]   k_reg;
    logic [63:0]     prod_reg;
    logic [32:0]     c_reg;
    logic [NST-1:0]  lane_done_reg;
    log_t            mx_reg;
    logic [34:0]     sum_reg;
    log_t            lnv_reg;
    log_t            ll_reg;
    logic            result_valid_reg;
    result_t         result_reg;

    logic            site_accept;
    logic            out_write;
    logic            any_zero_prior;
    log_t            emis [NST];
    logic [NST-1:0]  lane_done;
    log_res_t        lane_res [NST];
    logic [NST-1:0]  lane_all;
    logic            lane_flag;
    log_vec_t        lane_score;
    logic            ln_start;
    logic [63:0]     ln_v;
    logic [5:0]      ln_f;
    logic            ln_done;
    log_res_t        ln_res;
    logic            exp_start;
    logic [47:0]     exp_x;
    logic            exp_done;
    logic [32:0]     exp_res;
    logic [32:0]     mdiff;
    log_t            mx_val;
    log_res_t        ll_sum;

    assign site_accept    = site_valid && !site_stall;
    assign site_stall     = (state_reg != T_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_write      = (state_reg == T_OUT) && (!result_valid_reg || !result_stall);
    assign any_zero_prior = (prior_reg[0] == 17'd0) || (prior_reg[1] == 17'd0) ||
                            (prior_reg[2] == 17'd0) || (prior_reg[3] == 17'd0);

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            case (k)
                0:       emis[k] = site_reg.emission_0;
                1:       emis[k] = site_reg.emission_1;
                2:       emis[k] = site_reg.emission_2;
                default: emis[k] = site_reg.emission_3;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_lane
            hfl_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (state_reg == T_LANE_GO),
                .lane     (KW'(g)),
                .c        (c_reg),
                .prior    (prior_clamp(prior_reg[g])),
                .score    (score_reg),
                .emission (emis[g]),
                .done     (lane_done[g]),
                .result   (lane_res[g])
            );
        end
    endgenerate

    always_comb
    begin
        lane_flag = 1'b0;
        for (int k = 0; k < NST; k++)
        begin
            lane_score[k] = lane_res[k].value;
            lane_flag     = lane_flag | lane_res[k].flag;
        end
    end

    assign lane_all = lane_done_reg | lane_done;

    // merge stage units, also used for c and for loading the priors
    assign ln_start  = (state_reg == T_LOAD_GO) || (state_reg == T_MLN_GO);
    assign ln_v      = (state_reg == T_MLN_GO) ? 64'(sum_reg)
                                               : 64'(prior_clamp(prior_reg[2'(k_reg)]));
    assign ln_f      = (state_reg == T_MLN_GO) ? LN_F32 : LN_F16;
    assign exp_start = (state_reg == T_CEXP_GO) || (state_reg == T_MEXP_GO);
    assign mdiff     = 33'($signed({mx_reg[31], mx_reg}) -
                           $signed({score_reg[k_reg][31], score_reg[k_reg]}));
    assign exp_x     = (state_reg == T_MEXP_GO) ? 48'(mdiff) : prod_reg[63:16];
    assign mx_val    = max_log(score_reg);
    assign ll_sum    = sat_add(mx_reg, lnv_reg);

    hfl_ln u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .v      (ln_v),
        .fbits  (ln_f),
        .done   (ln_done),
        .result (ln_res)
    );

    hfl_exp u_exp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .x      (exp_x),
        .done   (exp_done),
        .result (exp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            decay_reg        <= 32'd0;
            prior_reg[0]     <= 17'd32768;
            prior_reg[1]     <= 17'd32768;
            prior_reg[2]     <= 17'd0;
            prior_reg[3]     <= 17'd0;
            open_reg         <= 1'b0;
            lane_done_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DECAY:  decay_reg    <= cfg_data;
                    REG_PRIOR0: prior_reg[0] <= cfg_data[16:0];
                    REG_PRIOR1: prior_reg[1] <= cfg_data[16:0];
                    REG_PRIOR2: prior_reg[2] <= cfg_data[16:0];
                    REG_PRIOR3: prior_reg[3] <= cfg_data[16:0];
                    default:    ;
                endcase
            end

            if (result_valid_reg && !result_stall && !out_write)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (site_accept)
                    begin
                        site_reg <= site;
                        k_reg    <= '0;
                        // ln of a zero prior is the only load-time saturation
                        flag_reg <= !open_reg && any_zero_prior;
                        state_reg <= open_reg ? T_MULT : T_LOAD_GO;
                    end
                end
                T_LOAD_GO:
                begin
                    state_reg <= T_LOAD_WAIT;
                end
                T_LOAD_WAIT:
                begin
                    if (ln_done)
                    begin
                        score_reg[k_reg] <= ln_res.value;
                        if (k_reg == KW'(NST - 1))
                        begin
                            open_reg  <= 1'b1;
                            state_reg <= T_MULT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= T_LOAD_GO;
                        end
                    end
                end
                T_MULT:
                begin
                    prod_reg  <= 64'(decay_reg) * 64'(site_reg.site_distance);
                    state_reg <= T_CEXP_GO;
                end
                T_CEXP_GO:
                begin
                    state_reg <= T_CEXP_WAIT;
                end
                T_CEXP_WAIT:
                begin
                    if (exp_done)
                    begin
                        c_reg     <= exp_res;
                        state_reg <= T_LANE_GO;
                    end
                end
                T_LANE_GO:
                begin
                    lane_done_reg <= '0;
                    state_reg     <= T_LANE_WAIT;
                end
                T_LANE_WAIT:
                begin
                    lane_done_reg <= lane_all;
                    if (&lane_all)
                    begin
                        score_reg <= lane_score;
                        flag_reg  <= flag_reg | lane_flag;
                        state_reg <= T_MMAX;
                    end
                end
                T_MMAX:
                begin
                    mx_reg  <= mx_val;
                    k_reg   <= '0;
                    sum_reg <= 35'd0;
                    if (mx_val == LOG_MIN)
                    begin
                        ll_reg    <= LOG_MIN;
                        state_reg <= T_OUT;
                    end
                    else
                    begin
                        state_reg <= T_MEXP_GO;
                    end
                end
                T_MEXP_GO:
                begin
                    state_reg <= T_MEXP_WAIT;
                end
                T_MEXP_WAIT:
                begin
                    if (exp_done)
                    begin
                        sum_reg <= sum_reg + 35'(exp_res);
                        if (k_reg == KW'(NST - 1))
                        begin
                            state_reg <= T_MLN_GO;
                        end
                        else
                        begin
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= T_MEXP_GO;
                        end
                    end
                end
                T_MLN_GO:
                begin
                    state_reg <= T_MLN_WAIT;
                end
                T_MLN_WAIT:
                begin
                    if (ln_done)
                    begin
                        lnv_reg   <= ln_res.value;
                        flag_reg  <= flag_reg | ln_res.flag;
                        state_reg <= T_MADD;
                    end
                end
                T_MADD:
                begin
                    ll_reg    <= ll_sum.value;
                    flag_reg  <= flag_reg | ll_sum.flag;
                    state_reg <= T_OUT;
                end
                T_OUT:
                begin
                    if (out_write)
                    begin
                        result_reg <= '{log_likelihood: ll_reg,
                                        sequence_end:   site_reg.final_site,
                                        saturated:      flag_reg};
                        result_valid_reg <= 1'b1;
                        if (site_reg.final_site)
                        begin
                            open_reg <= 1'b0;
                        end
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        site_accept |=> (state_reg != T_IDLE))
        else $error("site transfer did not start processing");

    a_lane_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (state_reg == T_LANE_WAIT))
        else $error("lane finished outside lane wait");

    a_exp_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        exp_done |-> (state_reg == T_CEXP_WAIT || state_reg == T_MEXP_WAIT))
        else $error("merge exp finished outside a wait state");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_write && site_reg.final_site) |=> !open_reg)
        else $error("sequence still open after final site");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hmm_forward_log_likelihood_top
// Sites are driven through a directed table and then at random, in bursts
// with gaps. A scoreboard model of the forward recursion predicts every
// running log-likelihood, and each result transfer is checked against the
// oldest prediction. Configuration is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;
    import hfl_pkg::*;

    localparam longint LIMIT = 64'd3000000;
    localparam int     DRAIN = 400;

    localparam logic [31:0] T_EXP2 [16] = '{
        32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
        32'd4202935003, 32'd4248701964, 32'd4271771997, 32'd4283353945,
        32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540,
        32'd4294603903, 32'd4294785596, 32'd4294876445, 32'd4294921870
    };

    typedef struct {
        site_t   s;
        bit      has_exp;
        result_t r;
    } vec_t;

    logic    clk;
    logic    rst_n;
    logic    site_valid;
    logic    site_stall;
    site_t   site;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // model state
    logic [31:0] m_rate;
    logic [16:0] m_prior [4];
    log_t        m_score [4];
    bit          m_open;

    result_t  ll_expected [$];
    result_t  ll_typed [$];
    bit       ll_is_typed [$];
    int       n_err;
    int       n_shown;
    longint   cycles;
    bit       hold_off;

    hmm_forward_log_likelihood_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .site_valid   (site_valid),
        .site_stall   (site_stall),
        .site         (site),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [63:0] exp_neg(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] r;
        if (x >= (64'd24 << 16))
            return 64'd0;
        y = (x * 64'd1549082005 + (64'd1 << 29)) >> 30;
        n = y >> 16;
        r = 64'd1 << 32;
        for (int b = 1; b <= 16; b++)
        begin
            if (y[16-b])
                r = (r * T_EXP2[b-1] + (64'd1 << 31)) >> 32;
        end
        if (n >= 33)
            return 64'd0;
        if (n > 0)
            r = (r + (64'd1 << (n - 1))) >> n;
        return r;
    endfunction

    function automatic log_t ln_q(input logic [63:0] v, input int fb, inout bit flag);
        int          m;
        logic [63:0] x;
        logic [63:0] frac;
        longint      lg;
        logic [127:0] mag;
        longint      r;
        bit          neg;
        if (v == 0)
        begin
            flag = 1;
            return LOG_MIN;
        end
        m = 63;
        while (!v[m])
            m--;
        x = (m >= 31) ? (v >> (m - 31)) : (v << (31 - m));
        frac = 0;
        for (int i = 0; i < 24; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                x = x >> 1;
            end
        end
        lg = longint'(m - fb) * (64'sd1 <<< 24) + longint'(frac);
        neg = lg < 0;
        mag = 128'(neg ? -lg : lg) * 128'd2977044472;
        r = longint'((mag + (128'd1 << 39)) >> 40);
        if (neg)
            r = -r;
        if (r <= -64'sd2147483648)
        begin
            flag = 1;
            return LOG_MIN;
        end
        if (r > 64'sd2147483647)
        begin
            flag = 1;
            return LOG_MAX;
        end
        return log_t'(r);
    endfunction

    function automatic log_t add_clamped(input log_t a, input log_t b, inout bit flag);
        longint s;
        if (a == LOG_MIN || b == LOG_MIN)
            return LOG_MIN;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647)
        begin
            flag = 1;
            return LOG_MAX;
        end
        if (s <= -64'sd2147483648)
        begin
            flag = 1;
            return LOG_MIN;
        end
        return log_t'(s);
    endfunction

    function automatic log_t lse(input log_t a [NST], inout bit flag);
        log_t        mx;
        logic [63:0] s;
        log_t        lv;
        mx = a[0];
        for (int i = 1; i < NST; i++)
            if (a[i] > mx)
                mx = a[i];
        if (mx == LOG_MIN)
            return LOG_MIN;
        s = 0;
        for (int i = 0; i < NST; i++)
            s += exp_neg(64'(longint'(mx) - longint'(a[i])));
        lv = ln_q(s, 32, flag);
        return add_clamped(mx, lv, flag);
    endfunction

    function automatic logic [63:0] clamped_prior(input int k);
        return (m_prior[k] > 17'd65536) ? 64'd65536 : 64'(m_prior[k]);
    endfunction

    function automatic result_t forward_site(input site_t s);
        bit          flag;
        logic [63:0] c;
        logic [63:0] off;
        logic [63:0] dia;
        log_t        lo;
        log_t        ld;
        log_t        sm;
        log_t        tmp [NST];
        log_t        nw [NST];
        log_t        em [4];
        result_t     r;
        flag = 0;
        if (!m_open)
        begin
            for (int k = 0; k < 4; k++)
                m_score[k] = ln_q(clamped_prior(k), 16, flag);
            m_open = 1;
        end
        em = '{s.emission_0, s.emission_1, s.emission_2, s.emission_3};
        c = exp_neg((64'(m_rate) * 64'(s.site_distance)) >> 16);
        for (int l = 0; l < NST; l++)
        begin
            off = ((64'd1 << 32) - c) * clamped_prior(l);
            dia = off + (c << 16);
            lo = ln_q(off, 48, flag);
            ld = ln_q(dia, 48, flag);
            for (int k = 0; k < NST; k++)
                tmp[k] = add_clamped(m_score[k], (k == l) ? ld : lo, flag);
            sm = lse(tmp, flag);
            nw[l] = add_clamped(sm, em[l], flag);
        end
        for (int l = 0; l < NST; l++)
            m_score[l] = nw[l];
        for (int l = 0; l < NST; l++)
            tmp[l] = m_score[l];
        r.log_likelihood = lse(tmp, flag);
        r.sequence_end   = s.final_site;
        r.saturated      = flag;
        if (s.final_site)
            m_open = 0;
        return r;
    endfunction

    // scoreboard side
    always @(posedge clk)
    begin
        result_t e;
        result_t t;
        if (rst_n && result_valid && !result_stall)
        begin
            if (ll_expected.size() == 0)
            begin
                n_err++;
                if (n_shown < 10)
                begin
                    n_shown++;
                    $display("unexpected result %h", result);
                end
            end
            else
            begin
                e = ll_expected.pop_front();
                if (ll_is_typed.pop_front())
                begin
                    t = ll_typed.pop_front();
                    if (t != e)
                    begin
                        n_err++;
                        if (n_shown < 10)
                        begin
                            n_shown++;
                            $display("typed entry disagrees with model: %h vs %h", t, e);
                        end
                    end
                end
                if (result.log_likelihood != e.log_likelihood
                    || result.sequence_end != e.sequence_end
                    || result.saturated != e.saturated)
                begin
                    n_err++;
                    if (n_shown < 10)
                    begin
                        n_shown++;
                        $display("mismatch: exp ll=%h end=%b sat=%b, got ll=%h end=%b sat=%b",
                                 e.log_likelihood, e.sequence_end, e.saturated,
                                 result.log_likelihood, result.sequence_end,
                                 result.saturated);
                    end
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int mode;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                result_stall <= 1'b1;
            else
            begin
                mode = int'((cycles / 5000) % 3);
                if (mode == 0)
                    result_stall <= 1'b0;
                else if (mode == 1)
                    result_stall <= ($urandom_range(0, 3) == 0);
                else
                    result_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one site transfer; the model predicts when it is taken
    task automatic send_site(input site_t s, input bit typed, input result_t tr);
        @(posedge clk);
        site_valid <= 1'b1;
        site       <= s;
        do
            @(posedge clk);
        while (site_stall);
        ll_expected.push_back(forward_site(s));
        ll_is_typed.push_back(typed);
        if (typed)
            ll_typed.push_back(tr);
        site_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DECAY)
            m_rate = val;
        else
            m_prior[idx - 1] = val[16:0];
    endtask

    task automatic drain();
        while (ll_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic site_t rand_site(input bit wild);
        site_t s;
        s.site_distance = wild ? $urandom() : $urandom_range(0, 32'h0004_0000);
        s.emission_0 = wild ? $urandom() : -$signed(32'($urandom_range(0, 32'h0010_0000)));
        s.emission_1 = wild ? $urandom() : -$signed(32'($urandom_range(0, 32'h0010_0000)));
        s.emission_2 = $urandom();
        s.emission_3 = $urandom();
        s.final_site = ($urandom_range(0, 7) == 0);
        return s;
    endfunction

    task automatic random_phase(input int count);
        int      left;
        int      burst;
        result_t none;
        none = '0;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && left > 0; i++, left--)
                send_site(rand_site($urandom_range(0, 9) == 0), 0, none);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 300)) @(posedge clk);
        end
    endtask

    initial
    begin
        vec_t    dir [$];
        vec_t    v;
        result_t none;
        none       = '0;
        rst_n      = 1'b0;
        site_valid = 1'b0;
        site       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_DECAY;
        cfg_data   = '0;
        hold_off   = 1'b0;
        n_err      = 0;
        n_shown    = 0;
        m_rate     = 0;
        m_prior    = '{17'd32768, 17'd32768, 17'd0, 17'd0};
        m_open     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: zero rate, zero emissions -> ln(0.5)+ln(1)... sum is 0,
        // off-diagonals are ln(0) so saturated
        v.s = '0;
        v.has_exp = 1;
        v.r.log_likelihood = 32'sd0;
        v.r.sequence_end = 1'b1;
        v.r.saturated = 1'b1;
        v.s.final_site = 1'b1;
        dir.push_back(v);
        v.has_exp = 0;
        v.s = '{32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 1'b0};
        dir.push_back(v);
        v.s = '{32'h0001_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 1'b1};
        dir.push_back(v);
        v.s = '{32'h0, LOG_MIN, LOG_MIN, LOG_MIN, LOG_MIN, 1'b1};
        dir.push_back(v);
        v.s = '{32'h0, LOG_MIN, 32'sh0, LOG_MAX, LOG_MIN, 1'b0};
        dir.push_back(v);
        v.s = '{32'h8000_0000, 32'sh8000_0001, 32'sh8000_0001, 32'sh1, 32'sh1, 1'b1};
        dir.push_back(v);
        foreach (dir[i])
            send_site(dir[i].s, dir[i].has_exp, dir[i].has_exp ? dir[i].r : none);
        drain();

        // rate, extreme and skewed priors
        write_reg(REG_DECAY, 32'h0001_0000);
        write_reg(REG_PRIOR0, 32'h0001_FFFF);
        write_reg(REG_PRIOR1, 32'h0000_0000);
        write_reg(REG_PRIOR2, 32'h0001_0000);
        write_reg(REG_PRIOR3, 32'h0000_0001);
        for (int i = 0; i < 8; i++)
            send_site(rand_site(i[0]), 0, none);
        drain();

        write_reg(REG_DECAY, 32'hFFFF_FFFF);
        write_reg(REG_PRIOR0, 32'd1);
        write_reg(REG_PRIOR1, 32'd65535);
        write_reg(REG_PRIOR2, 32'h0001_FFFF);
        write_reg(REG_PRIOR3, 32'd0);
        random_phase(150);

        // long receiver hold-off while sites keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(30);
        join
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_DECAY, (ph == 0) ? 32'd0 : $urandom_range(0, 32'h0004_0000));
            write_reg(REG_PRIOR0, $urandom_range(0, 65536));
            write_reg(REG_PRIOR1, $urandom_range(0, 65536));
            write_reg(REG_PRIOR2, $urandom_range(0, 32'h1_FFFF));
            write_reg(REG_PRIOR3, $urandom_range(0, 32'h1_FFFF));
            random_phase(190);
            drain();
        end

        if (n_err == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== hmm_forward_log_likelihood_top.f =====
rtl/hfl_pkg.sv
rtl/hfl_exp.sv
rtl/hfl_ln.sv
rtl/hfl_lane.sv
rtl/hmm_forward_log_likelihood_top.sv
dv/tb.sv
